// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge while out of reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property at every rising edge, reset included.
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hw/rtl/rxpc_pkg.sv
package rxpc_pkg;

  // Key derivation and key step constants
  localparam logic [31:0] KEY_BASE  = 32'h930F_D7E2;
  localparam logic [31:0] SEED_MASK = 32'h9C30_D539;
  localparam logic [31:0] KEY_MIX   = 32'h7C72_E993;
  localparam logic [31:0] KEY_STEP  = 32'h287E_FFC3;

  // Configuration register indexes
  localparam logic [0:0] REG_KEY_SEED      = 1'b0;
  localparam logic [0:0] REG_CIPHER_ENABLE = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
    logic       end_of_packet;
  } rxpc_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       final_of_packet;
    logic       short_packet;
  } rxpc_out_t;

  // Pick key byte n (byte n is bits 8n+7..8n)
  function automatic logic [7:0] kbyte(input logic [63:0] k, input logic [2:0] n);
    return k[{n, 3'b000} +: 8];
  endfunction

  function automatic logic [31:0] bswap32(input logic [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  // Both keys start from the seed: low word a, high word b
  function automatic logic [63:0] derive_key(input logic [31:0] seed);
    logic [31:0] r;
    logic [31:0] a;
    logic [31:0] b;
    r = seed ^ SEED_MASK;
    a = {r[12:0], r[31:13]};
    b = a ^ KEY_BASE ^ KEY_MIX;
    return {b, a};
  endfunction

  // Fold the plaintext head into the low word, step the big-endian high word
  function automatic logic [63:0] next_key(input logic [63:0] k, input logic [31:0] plain);
    logic [63:0] kx;
    logic [31:0] w;
    kx = k ^ {32'h0, plain};
    w  = bswap32(kx[63:32]) + KEY_STEP;
    return {bswap32(w), kx[31:0]};
  endfunction

endpackage

// File: hw/rtl/rolling_xor_packet_cipher.sv
// Rolling XOR packet cipher. Each accepted request is one payload byte; the
// direction (encrypt or decrypt) is latched from the first byte of a packet.
// Bytes stream at one per cycle through a single registered pass, unless a
// stalled result or a draining hold register holds in_ready low. The first
// three bytes of a packet give no result; the fourth gives four results, the
// first at once and the other three in turn from a hold register, during
// which in_ready stays low. A packet that ends before its fourth byte gives
// one error result (out_byte 0, short_packet 1). Writing key_seed rederives
// both keys; with cipher_enable at 0 bytes pass through unchanged.
// Configuration writes are meant for idle periods only.
module rolling_xor_packet_cipher
  import rxpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  rxpc_in_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output rxpc_out_t   out_data,
  input  logic        cfg_wr_en,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  logic             enable_r, enable_nxt;
  logic [63:0]      enc_key_r, enc_key_nxt;
  logic [63:0]      dec_key_r, dec_key_nxt;
  logic [2:0][7:0]  head_r, head_nxt;
  logic [3:0][7:0]  plain_r, plain_nxt;
  logic [7:0]       chain_r, chain_nxt;
  logic [2:0]       pos_r, pos_nxt;
  logic             dir_r, dir_nxt;
  logic             stream_r, stream_nxt;
  logic [2:0][7:0]  hold_r, hold_nxt;
  logic             hold_fin_r, hold_fin_nxt;
  logic [1:0]       hold_cnt_r, hold_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  rxpc_out_t        out_data_r, out_data_nxt;

  logic             in_fire;
  logic             out_free;
  logic             dir;
  logic [63:0]      key;
  logic [7:0]       b;
  logic             eop;
  logic [7:0]       stream_byte;
  logic [7:0]       e0, e1, e2, e3;
  logic [7:0]       u0, u1, u2, u3;
  logic [3:0][7:0]  enc_o, dec_o, head_o;
  logic [7:0]       head_chain;
  logic [3:0][7:0]  head_plain;
  logic             key_upd;
  logic [31:0]      upd_plain;
  logic [63:0]      upd_key;
  logic             has_first;
  rxpc_out_t        first;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (hold_cnt_r == 2'd0) && out_free;
  assign in_fire  = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign b   = in_data.data_byte;
  assign eop = in_data.end_of_packet;

  // Latch direction on the first byte of a packet
  assign dir = (!stream_r && pos_r == 3'd0) ? in_data.operation : dir_r;
  assign key = dir ? dec_key_r : enc_key_r;

  // Chained byte after the head
  assign stream_byte = b ^ kbyte(key, pos_r) ^ chain_r;

  // Encrypt head: chain forward, then backward fixup
  always_comb begin
    e0 = head_r[0] ^ kbyte(key, 3'd0);
    e1 = head_r[1] ^ kbyte(key, 3'd1) ^ e0;
    e2 = head_r[2] ^ kbyte(key, 3'd2) ^ e1;
    e3 = b         ^ kbyte(key, 3'd3) ^ e2;
    enc_o[3] = e3 ^ kbyte(key, 3'd2);
    enc_o[2] = e2 ^ kbyte(key, 3'd3) ^ enc_o[3];
    enc_o[1] = e1 ^ kbyte(key, 3'd4) ^ enc_o[2];
    enc_o[0] = e0 ^ kbyte(key, 3'd5) ^ enc_o[1];
  end

  // Decrypt head: undo the fixup, then chain forward
  always_comb begin
    u3 = b ^ kbyte(key, 3'd2);
    u2 = head_r[2] ^ b ^ kbyte(key, 3'd3);
    u1 = head_r[1] ^ head_r[2] ^ kbyte(key, 3'd4);
    u0 = head_r[0] ^ head_r[1] ^ kbyte(key, 3'd5);
    dec_o[0] = u0 ^ kbyte(key, 3'd0);
    dec_o[1] = u1 ^ kbyte(key, 3'd1) ^ u0;
    dec_o[2] = u2 ^ kbyte(key, 3'd2) ^ u1;
    dec_o[3] = u3 ^ kbyte(key, 3'd3) ^ u2;
  end

  assign head_o     = dir ? dec_o : enc_o;
  assign head_chain = dir ? u3 : e3;
  assign head_plain = dir ? dec_o : {b, head_r[2], head_r[1], head_r[0]};

  // Per-request state update
  always_comb begin
    enable_nxt   = enable_r;
    head_nxt     = head_r;
    plain_nxt    = plain_r;
    chain_nxt    = chain_r;
    pos_nxt      = pos_r;
    dir_nxt      = dir_r;
    stream_nxt   = stream_r;
    hold_nxt     = hold_r;
    hold_fin_nxt = hold_fin_r;
    hold_cnt_nxt = hold_cnt_r;
    key_upd      = 1'b0;
    upd_plain    = plain_r;
    has_first    = 1'b0;
    first        = '0;

    if (in_fire) begin
      if (!enable_r) begin
        // Pass through and drop any partial packet
        has_first  = 1'b1;
        first      = '{out_byte: b, final_of_packet: eop, short_packet: 1'b0};
        pos_nxt    = 3'd0;
        stream_nxt = 1'b0;
      end else begin
        dir_nxt = dir;
        if (stream_r) begin
          has_first = 1'b1;
          first     = '{out_byte: stream_byte, final_of_packet: eop, short_packet: 1'b0};
          chain_nxt = dir ? b : stream_byte;
          pos_nxt   = pos_r + 3'd1;
          key_upd   = eop;
        end else if (pos_r == 3'd3) begin
          // Fourth head byte: emit one result now, hold three
          has_first    = 1'b1;
          first        = '{out_byte: head_o[0], final_of_packet: 1'b0, short_packet: 1'b0};
          hold_nxt     = {head_o[3], head_o[2], head_o[1]};
          hold_fin_nxt = eop;
          hold_cnt_nxt = 2'd3;
          plain_nxt    = head_plain;
          upd_plain    = head_plain;
          chain_nxt    = head_chain;
          stream_nxt   = 1'b1;
          pos_nxt      = 3'd4;
          key_upd      = eop;
        end else begin
          // Buffer an early head byte
          unique case (pos_r[1:0])
            2'd0:    head_nxt[0] = b;
            2'd1:    head_nxt[1] = b;
            default: head_nxt[2] = b;
          endcase
          if (eop) begin
            has_first = 1'b1;
            first     = '{out_byte: 8'h00, final_of_packet: 1'b1, short_packet: 1'b1};
            pos_nxt   = 3'd0;
          end else begin
            pos_nxt = pos_r + 3'd1;
          end
        end
        if (key_upd) begin
          pos_nxt    = 3'd0;
          stream_nxt = 1'b0;
        end
      end
    end else if (hold_cnt_r != 2'd0 && out_free) begin
      // Advance the hold register
      hold_nxt     = {8'h00, hold_r[2], hold_r[1]};
      hold_cnt_nxt = hold_cnt_r - 2'd1;
    end

    if (cfg_wr_en && cfg_index == REG_CIPHER_ENABLE) begin
      enable_nxt = cfg_wdata[0];
    end
  end

  // Key update at the end of a ciphered packet of four or more bytes; seed write rederives both keys
  assign upd_key = next_key(key, upd_plain);

  always_comb begin
    enc_key_nxt = enc_key_r;
    dec_key_nxt = dec_key_r;
    if (cfg_wr_en && cfg_index == REG_KEY_SEED) begin
      enc_key_nxt = derive_key(cfg_wdata);
      dec_key_nxt = derive_key(cfg_wdata);
    end else if (key_upd) begin
      if (dir) begin
        dec_key_nxt = upd_key;
      end else begin
        enc_key_nxt = upd_key;
      end
    end
  end

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (in_fire && has_first) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = first;
    end else if (!in_fire && hold_cnt_r != 2'd0 && out_free) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '{out_byte:        hold_r[0],
                        final_of_packet: (hold_cnt_r == 2'd1) ? hold_fin_r : 1'b0,
                        short_packet:    1'b0};
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control and key state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b0;
      enc_key_r   <= derive_key(32'h0);
      dec_key_r   <= derive_key(32'h0);
      head_r      <= '0;
      plain_r     <= '0;
      chain_r     <= 8'h00;
      pos_r       <= 3'd0;
      dir_r       <= 1'b0;
      stream_r    <= 1'b0;
      hold_cnt_r  <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      enable_r    <= enable_nxt;
      enc_key_r   <= enc_key_nxt;
      dec_key_r   <= dec_key_nxt;
      head_r      <= head_nxt;
      plain_r     <= plain_nxt;
      chain_r     <= chain_nxt;
      pos_r       <= pos_nxt;
      dir_r       <= dir_nxt;
      stream_r    <= stream_nxt;
      hold_cnt_r  <= hold_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    hold_r     <= hold_nxt;
    hold_fin_r <= hold_fin_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// File: hw/rtl/rxpc_checker.sv
`include "assert_macros.svh"

module rxpc_checker
  import rxpc_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input rxpc_out_t   out_data
);

  logic stalled;
  logic err_shown;
  logic err_form;

  assign stalled   = out_valid && !out_ready;
  assign err_shown = out_valid && out_data.short_packet;
  assign err_form  = out_data.final_of_packet && (out_data.out_byte == 8'h00);

  // No result is shown right after reset
  `ASSERT_CLK_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result valid after reset")

  // A stalled result blocks new requests
  `ASSERT_CLK(a_stall_blocks, clk, rst_n, stalled |-> !in_ready, "request taken while stalled")

  // An error result is a zero byte that closes the packet
  `ASSERT_CLK(a_short_form, clk, rst_n, err_shown |-> err_form, "bad short packet result")

  // A stalled result holds
  `ASSERT_CLK(a_out_hold, clk, rst_n, stalled |=> out_valid && $stable(out_data), "result not held")

endmodule

bind rolling_xor_packet_cipher rxpc_checker u_rxpc_checker (.*);
